FILE: hw/rtl/dpu_pkg.sv
// shared constants and types of the depth pixel unprojection block
package dpu_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;

  localparam int INV_BITS    = 24;
  localparam int CENTER_BITS = 16;
  localparam int STEP_BITS   = 5;
  localparam int COLOUR_BITS = 8;
  localparam int POINT_BITS  = 33;
  localparam int FRAC_SHIFT  = 24;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INV_FOCAL_X    = 3'd0,
    REG_INV_FOCAL_Y    = 3'd1,
    REG_CENTER_X       = 3'd2,
    REG_CENTER_Y       = 3'd3,
    REG_SUBSAMPLE_STEP = 3'd4
  } cfg_reg_t;

  localparam logic [INV_BITS-1:0]    INV_FOCAL_X_RST    = 24'd29433;
  localparam logic [INV_BITS-1:0]    INV_FOCAL_Y_RST    = 24'd29433;
  localparam logic [CENTER_BITS-1:0] CENTER_X_RST       = 16'd5120;
  localparam logic [CENTER_BITS-1:0] CENTER_Y_RST       = 16'd3840;
  localparam logic [STEP_BITS-1:0]   SUBSAMPLE_STEP_RST = 5'd1;

  localparam logic signed [63:0] POINT_MAX = 64'sd4294967295;
  localparam logic signed [63:0] POINT_MIN = -64'sd4294967296;

  // load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

FILE: hw/rtl/dpu_if.sv
// request channels of the depth pixel unprojection block

interface dpu_pixel_if
  import dpu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [DEPTH_BITS-1:0]  depth_mm;
  logic [COLOUR_BITS-1:0] pixel_blue;
  logic [COLOUR_BITS-1:0] pixel_green;
  logic [COLOUR_BITS-1:0] pixel_red;
  logic [COORD_BITS-1:0]  pixel_column;
  logic [COORD_BITS-1:0]  pixel_row;
  logic                   frame_end_in;

  modport source (
    output valid, depth_mm, pixel_blue, pixel_green, pixel_red,
           pixel_column, pixel_row, frame_end_in,
    input  ready
  );
  modport sink (
    input  valid, depth_mm, pixel_blue, pixel_green, pixel_red,
           pixel_column, pixel_row, frame_end_in,
    output ready
  );
endinterface

interface dpu_point_if
  import dpu_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic [DEPTH_BITS-1:0]        point_z;
  logic [COLOUR_BITS-1:0]       point_red;
  logic [COLOUR_BITS-1:0]       point_green;
  logic [COLOUR_BITS-1:0]       point_blue;
  logic                         point_valid;
  logic                         frame_end_out;

  modport source (
    output valid, point_x, point_y, point_z, point_red, point_green, point_blue,
           point_valid, frame_end_out,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, point_red, point_green, point_blue,
           point_valid, frame_end_out,
    output ready
  );
endinterface

interface dpu_cfg_if
  import dpu_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dpu_axis_lane.sv
// one axis of the unprojection: stride test and pipelined fixed-point scaling
module dpu_axis_lane
  import dpu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                         clk,
  input  stage_en_t                    en,
  input  logic [COORD_BITS-1:0]        pos,
  input  logic [CENTER_BITS-1:0]       center,
  input  logic [INV_BITS-1:0]          inv,
  input  logic [STEP_BITS-1:0]         step,
  input  logic [DEPTH_BITS-1:0]        depth,
  output logic                         divisible,
  output logic signed [POINT_BITS-1:0] coord
);

  localparam int PW16 = COORD_BITS + 4;
  localparam int MW   = (PW16 > CENTER_BITS) ? PW16 : CENTER_BITS;
  localparam int MDW  = MW + DEPTH_BITS;
  localparam int LW   = (MDW + 1) / 2;
  localparam int HW   = MDW - LW;
  localparam int PW   = MDW + INV_BITS;
  localparam int SW   = PW + 1 - FRAC_SHIFT;
  localparam int LB   = COORD_BITS / 2;
  localparam int UB   = COORD_BITS - LB;

  // stage 1
  logic [MW-1:0]          mag1;
  logic                   neg1;
  logic [STEP_BITS-1:0]   rem1;
  logic [LB-1:0]          low1;
  // stage 2
  logic [MDW-1:0]         md2;
  logic                   neg2;
  // stage 3
  logic [LW+INV_BITS-1:0] pp_lo3;
  logic [HW+INV_BITS-1:0] pp_hi3;
  logic                   neg3;
  // stage 4
  logic [PW-1:0]          prod4;
  logic                   neg4;

  logic [MW-1:0]          p16_w;
  logic [MW-1:0]          center_w;
  logic                   neg_c;
  logic [MW-1:0]          mag_c;
  logic [STEP_BITS:0]     divisor;
  logic [STEP_BITS:0]     rem_hi;
  logic [STEP_BITS:0]     rem_lo;
  logic signed [PW:0]     signed_prod;
  logic signed [PW:0]     shifted;
  logic signed [SW-1:0]   scaled;
  logic signed [63:0]     scaled_wide;

  // a step of zero behaves as one
  assign divisor = (step == '0) ? (STEP_BITS+1)'(1) : {1'b0, step};

  always_comb begin
    p16_w    = MW'({pos, 4'b0000});
    center_w = MW'(center);
    neg_c    = p16_w < center_w;
    mag_c    = neg_c ? (center_w - p16_w) : (p16_w - center_w);
  end

  // restoring remainder, upper half of the coordinate bits
  always_comb begin
    rem_hi = '0;
    for (int i = UB - 1; i >= 0; i--) begin
      rem_hi = {rem_hi[STEP_BITS-1:0], pos[LB + i]};
      if (rem_hi >= divisor) rem_hi = rem_hi - divisor;
    end
  end

  // lower half continues from the stored partial remainder
  always_comb begin
    rem_lo = {1'b0, rem1};
    for (int i = LB - 1; i >= 0; i--) begin
      rem_lo = {rem_lo[STEP_BITS-1:0], low1[i]};
      if (rem_lo >= divisor) rem_lo = rem_lo - divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag1 <= mag_c;
      neg1 <= neg_c;
      rem1 <= rem_hi[STEP_BITS-1:0];
      low1 <= pos[LB-1:0];
    end
    if (en.s2) begin
      md2       <= MDW'(mag1) * MDW'(depth);
      neg2      <= neg1;
      divisible <= (rem_lo == '0);
    end
    if (en.s3) begin
      pp_lo3 <= (LW+INV_BITS)'(md2[LW-1:0]) * (LW+INV_BITS)'(inv);
      pp_hi3 <= (HW+INV_BITS)'(md2[MDW-1:LW]) * (HW+INV_BITS)'(inv);
      neg3   <= neg2;
    end
    if (en.s4) begin
      prod4 <= (PW'(pp_hi3) << LW) + PW'(pp_lo3);
      neg4  <= neg3;
    end
  end

  // floor division by 2^24 of a signed product is an arithmetic shift
  always_comb begin
    signed_prod = neg4 ? -$signed({1'b0, prod4}) : $signed({1'b0, prod4});
    shifted     = signed_prod >>> FRAC_SHIFT;
    scaled      = $signed(shifted[SW-1:0]);
    scaled_wide = 64'(scaled);
    if (scaled_wide > POINT_MAX) begin
      coord = POINT_MAX[POINT_BITS-1:0];
    end else if (scaled_wide < POINT_MIN) begin
      coord = POINT_MIN[POINT_BITS-1:0];
    end else begin
      coord = scaled_wide[POINT_BITS-1:0];
    end
  end

endmodule

FILE: hw/rtl/depth_pixel_to_point_unproject.sv
// Pinhole back-projection of depth pixels into coloured points. One pixel
// request is taken every clock unless the output stall reaches the input, and
// its point passes through four pipeline stages (offset and stride remainder,
// depth multiply, split reciprocal multiply, product sum), the first loaded at
// the taking edge, and the output register, where the sign, floor shift and
// saturation are applied. The latency is set by the 56-bit product, which is
// built from two 16 by 24 bit partial products.
// Pixels off the stride or with zero depth give no point, except the frame's
// last pixel, which always gives one (flagged not valid, fields zero, when
// dropped). A stalled output holds the pipeline back stage by stage, so
// bubbles are squeezed out. Configuration writes are taken in any cycle and
// must only be made while no pixel is in flight.
module depth_pixel_to_point_unproject
  import dpu_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dpu_pixel_if.sink    pixel,
  dpu_point_if.source  point,
  dpu_cfg_if.sink      cfg
);

  logic [INV_BITS-1:0]    inv_focal_x;
  logic [INV_BITS-1:0]    inv_focal_y;
  logic [CENTER_BITS-1:0] center_x;
  logic [CENTER_BITS-1:0] center_y;
  logic [STEP_BITS-1:0]   subsample_step;

  logic v1, v2, v3, v4, o_v;
  logic ld1, ld2, ld3, ld4, ld_o;
  stage_en_t en;

  logic [DEPTH_BITS-1:0]  depth1, depth2, depth3, depth4;
  logic [COLOUR_BITS-1:0] blue1, blue2, blue3, blue4;
  logic [COLOUR_BITS-1:0] green1, green2, green3, green4;
  logic [COLOUR_BITS-1:0] red1, red2, red3, red4;
  logic                   last1, last2, last3, last4;
  logic                   kept3, kept4;
  logic                   kept2_c;

  logic                         div_x, div_y;
  logic signed [POINT_BITS-1:0] coord_x, coord_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_focal_x    <= INV_FOCAL_X_RST;
      inv_focal_y    <= INV_FOCAL_Y_RST;
      center_x       <= CENTER_X_RST;
      center_y       <= CENTER_Y_RST;
      subsample_step <= SUBSAMPLE_STEP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INV_FOCAL_X:    inv_focal_x    <= cfg.data[INV_BITS-1:0];
        REG_INV_FOCAL_Y:    inv_focal_y    <= cfg.data[INV_BITS-1:0];
        REG_CENTER_X:       center_x       <= cfg.data[CENTER_BITS-1:0];
        REG_CENTER_Y:       center_y       <= cfg.data[CENTER_BITS-1:0];
        REG_SUBSAMPLE_STEP: subsample_step <= cfg.data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // each stage loads when it is empty or its contents move on
  assign ld_o = !o_v || point.ready;
  assign ld4  = !v4 || ld_o;
  assign ld3  = !v3 || ld4;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;
  assign pixel.ready = ld1;
  assign en = '{s1: ld1, s2: ld2, s3: ld3, s4: ld4};

  assign kept2_c = div_x && div_y && (depth2 != '0);

  dpu_axis_lane #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) u_lane_x (
    .clk       (clk),
    .en        (en),
    .pos       (pixel.pixel_column),
    .center    (center_x),
    .inv       (inv_focal_x),
    .step      (subsample_step),
    .depth     (depth1),
    .divisible (div_x),
    .coord     (coord_x)
  );

  dpu_axis_lane #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) u_lane_y (
    .clk       (clk),
    .en        (en),
    .pos       (pixel.pixel_row),
    .center    (center_y),
    .inv       (inv_focal_y),
    .step      (subsample_step),
    .depth     (depth1),
    .divisible (div_y),
    .coord     (coord_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (ld1) v1 <= pixel.valid;
      if (ld2) v2 <= v1;
      // pixels that give no point leave the pipeline here
      if (ld3) v3 <= v2 && (kept2_c || last2);
      if (ld4) v4 <= v3;
      if (ld_o) o_v <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      depth1 <= pixel.depth_mm;
      blue1  <= pixel.pixel_blue;
      green1 <= pixel.pixel_green;
      red1   <= pixel.pixel_red;
      last1  <= pixel.frame_end_in;
    end
    if (ld2) begin
      depth2 <= depth1;
      blue2  <= blue1;
      green2 <= green1;
      red2   <= red1;
      last2  <= last1;
    end
    if (ld3) begin
      depth3 <= depth2;
      blue3  <= blue2;
      green3 <= green2;
      red3   <= red2;
      last3  <= last2;
      kept3  <= kept2_c;
    end
    if (ld4) begin
      depth4 <= depth3;
      blue4  <= blue3;
      green4 <= green3;
      red4   <= red3;
      last4  <= last3;
      kept4  <= kept3;
    end
    if (ld_o) begin
      point.point_x       <= kept4 ? coord_x : '0;
      point.point_y       <= kept4 ? coord_y : '0;
      point.point_z       <= kept4 ? depth4 : '0;
      point.point_red     <= kept4 ? red4 : '0;
      point.point_green   <= kept4 ? green4 : '0;
      point.point_blue    <= kept4 ? blue4 : '0;
      point.point_valid   <= kept4;
      point.frame_end_out <= last4;
    end
  end

  assign point.valid = o_v;

  // a dropped pixel only reaches the output when it ends the frame
  assert property (@(posedge clk) disable iff (rst)
    point.valid && !point.point_valid |-> point.frame_end_out)
    else $error("dropped pixel produced a point without frame end");

  assert property (@(posedge clk) disable iff (rst)
    point.valid && !point.point_valid |-> point.point_z == '0)
    else $error("dropped point carries nonzero depth");

  assert property (@(posedge clk) disable iff (rst)
    point.valid && point.point_valid |-> point.point_z != '0)
    else $error("kept point has zero depth");

  // a stalled stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    v4 && !ld4 |=> v4)
    else $error("stalled stage four lost its item");

  assert property (@(posedge clk) disable iff (rst)
    v1 && !ld1 |=> v1)
    else $error("stalled stage one lost its item");

endmodule
